>>> design/osr_pkg.sv
// Shared types and constants for the oversampled serial receiver.
// No dependencies; used by osr_core, osr_out_buf and the top level.

package osr_pkg;

    localparam int unsigned START_RUN_LIMIT = 10;
    localparam int unsigned DATA_BITS       = 8;

    localparam int unsigned PERIOD_W = 10;
    localparam int unsigned BYTE_W   = 8;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 10'd100;

    typedef struct packed {
        logic [BYTE_W-1:0] received_byte;
        logic              parity_error;
    } osr_result_t;

endpackage

>>> design/osr_core.sv
// Sample-by-sample receive state machine: start hunt, start skip, bit voting.
// Depends on osr_pkg for constants and the result struct.

module osr_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [osr_pkg::PERIOD_W-1:0]        cfg_data,
    input  logic                                step_en,
    input  logic                                sample,
    output logic                                result_valid,
    output osr_pkg::osr_result_t                result
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_SKIP = 2'd1,
        PH_BITS = 2'd2,
        PH_SPARE = 2'd3
    } phase_t;

    localparam logic [3:0] RUN_LIMIT = 4'(osr_pkg::START_RUN_LIMIT);
    localparam logic [3:0] NUM_BITS  = 4'(osr_pkg::DATA_BITS);
    localparam logic [osr_pkg::PERIOD_W-1:0] START_COUNT =
        osr_pkg::PERIOD_W'(osr_pkg::START_RUN_LIMIT + 1);

    phase_t                         phase_reg, phase_next;
    logic [3:0]                     low_run_reg, low_run_next;
    logic [osr_pkg::PERIOD_W-1:0]   count_reg, count_next;
    logic [osr_pkg::PERIOD_W-1:0]   high_reg, high_next;
    logic [osr_pkg::PERIOD_W-1:0]   low_reg, low_next;
    logic [3:0]                     index_reg, index_next;
    logic [osr_pkg::BYTE_W-1:0]     shift_reg, shift_next;
    logic                           parity_reg, parity_next;
    logic [osr_pkg::PERIOD_W-1:0]   period_reg;

    logic [osr_pkg::PERIOD_W-1:0]   count_inc;
    logic [osr_pkg::PERIOD_W-1:0]   high_inc;
    logic [osr_pkg::PERIOD_W-1:0]   low_inc;
    logic                           bit_val;

    assign count_inc = count_reg + 1'b1;
    assign high_inc  = sample ? high_reg + 1'b1 : high_reg;
    assign low_inc   = sample ? low_reg : low_reg + 1'b1;
    assign bit_val   = (high_inc > low_inc);

    always_comb begin
        phase_next   = phase_reg;
        low_run_next = low_run_reg;
        count_next   = count_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        index_next   = index_reg;
        shift_next   = shift_reg;
        parity_next  = parity_reg;
        result_valid = 1'b0;
        result.received_byte = shift_reg;
        result.parity_error  = parity_reg ^ bit_val;

        unique case (phase_reg)
            PH_SKIP: begin
                count_next = count_inc;
                if (count_inc >= period_reg) begin
                    phase_next = PH_BITS;
                    count_next = '0;
                    high_next  = '0;
                    low_next   = '0;
                end
            end
            PH_BITS: begin
                high_next  = high_inc;
                low_next   = low_inc;
                count_next = count_inc;
                if (count_inc >= period_reg) begin
                    count_next = '0;
                    high_next  = '0;
                    low_next   = '0;
                    if (index_reg < NUM_BITS) begin
                        shift_next  = {shift_reg[osr_pkg::BYTE_W-2:0], bit_val};
                        parity_next = parity_reg ^ bit_val;
                        index_next  = index_reg + 1'b1;
                    end else begin
                        // parity window closed: emit and go back to hunting
                        result_valid = 1'b1;
                        phase_next   = PH_HUNT;
                        low_run_next = '0;
                        index_next   = '0;
                        shift_next   = '0;
                        parity_next  = 1'b0;
                    end
                end
            end
            default: begin
                phase_next = PH_HUNT;
                if (sample) begin
                    low_run_next = '0;
                end else if (low_run_reg >= RUN_LIMIT) begin
                    low_run_next = '0;
                    high_next    = '0;
                    low_next     = '0;
                    index_next   = '0;
                    shift_next   = '0;
                    parity_next  = 1'b0;
                    if (START_COUNT < period_reg) begin
                        phase_next = PH_SKIP;
                        count_next = START_COUNT;
                    end else begin
                        phase_next = PH_BITS;
                        count_next = '0;
                    end
                end else begin
                    low_run_next = low_run_reg + 1'b1;
                end
            end
        endcase

        if (!step_en) begin
            result_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            low_run_reg <= '0;
            count_reg   <= '0;
            high_reg    <= '0;
            low_reg     <= '0;
            index_reg   <= '0;
            shift_reg   <= '0;
            parity_reg  <= 1'b0;
            period_reg  <= osr_pkg::BIT_PERIOD_RESET;
        end else begin
            if (cfg_we) begin
                period_reg <= cfg_data;
            end
            if (step_en) begin
                phase_reg   <= phase_next;
                low_run_reg <= low_run_next;
                count_reg   <= count_next;
                high_reg    <= high_next;
                low_reg     <= low_next;
                index_reg   <= index_next;
                shift_reg   <= shift_next;
                parity_reg  <= parity_next;
            end
        end
    end

    a_result_from_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        result_valid |-> (phase_reg == PH_BITS && index_reg == NUM_BITS))
        else $error("result raised outside the parity window");

    a_result_then_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        result_valid |=> (phase_reg == PH_HUNT && index_reg == '0 && low_run_reg == '0))
        else $error("receiver did not return to hunting after a result");

    a_votes_match_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BITS) |-> (high_reg + low_reg == count_reg))
        else $error("vote totals disagree with the window sample count");

endmodule

>>> design/osr_out_buf.sv
// Two-entry result buffer: output register plus skid slot.
// Depends on osr_pkg for the result struct.

module osr_out_buf (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  osr_pkg::osr_result_t    push_data,
    output logic                    full,
    output logic                    m_valid,
    input  logic                    m_ready,
    output osr_pkg::osr_result_t    head
);

    logic [1:0]             count_reg, count_next;
    osr_pkg::osr_result_t   head_reg, head_next;
    osr_pkg::osr_result_t   skid_reg, skid_next;
    logic                   pop;

    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign head    = head_reg;
    assign pop     = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        skid_next  = skid_reg;
        if (push && !pop) begin
            if (count_reg == 2'd0) begin
                head_next = push_data;
            end else begin
                skid_next = push_data;
            end
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            head_next  = skid_reg;
            count_next = count_reg - 1'b1;
        end else if (push && pop) begin
            // head leaves, queue advances by one
            if (count_reg == 2'd1) begin
                head_next = push_data;
            end else begin
                head_next = skid_reg;
                skid_next = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("result pushed into a full buffer");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("buffer count out of range");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && count_reg == 2'd0) |=> (m_valid && head_reg == $past(push_data)))
        else $error("pushed result not presented at the output");

endmodule

>>> design/oversampled_serial_receiver_unit.sv
// Top level of the oversampled serial receiver (8 data bits, even parity).
// Depends on osr_pkg, osr_core and osr_out_buf.
//
//   channel   direction  handshake            beat payload
//   s_        in         s_valid / s_ready    s_line_sample
//   m_        out        m_valid / m_ready    m_received_byte, m_parity_error
//   cfg_      in         cfg_valid/cfg_ready  cfg_data (bit_period)
//
// One line sample is taken per cycle while s_ready is high; a sample goes through
// the input register, then the state update, and a result shows on m_ once the
// update that closes the parity window has pushed it into the output buffer.
// Reset sets bit_period to 100 and puts the receiver in start-bit hunt.
// When m_ stalls, a two-entry output buffer keeps taking results; s_ready
// drops only while that buffer is full and a sample waits in the input register.
// cfg_ready is always high.

module oversampled_serial_receiver_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_line_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [osr_pkg::BYTE_W-1:0]      m_received_byte,
    output logic                            m_parity_error,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [osr_pkg::PERIOD_W-1:0]    cfg_data
);

    logic                   in_valid_reg;
    logic                   in_sample_reg;
    logic                   buf_full;
    logic                   advance;
    logic                   core_valid;
    osr_pkg::osr_result_t   core_result;
    osr_pkg::osr_result_t   out_head;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && !buf_full;
    assign s_ready   = !in_valid_reg || !buf_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_sample_reg <= s_line_sample;
        end
    end

    osr_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .step_en      (advance),
        .sample       (in_sample_reg),
        .result_valid (core_valid),
        .result       (core_result)
    );

    osr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (core_valid),
        .push_data (core_result),
        .full      (buf_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .head      (out_head)
    );

    assign m_received_byte = out_head.received_byte;
    assign m_parity_error  = out_head.parity_error;

    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && buf_full) |=> (in_valid_reg && in_sample_reg == $past(in_sample_reg)))
        else $error("waiting sample lost while the output buffer was full");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && buf_full))
        else $error("input stalled without a full pipeline");

endmodule

>>> test/tb_oversampled_serial_receiver_unit.sv
// Testbench for oversampled_serial_receiver_unit: drives framed and noisy line samples
// across many bit periods, predicts each received byte and parity flag, checks m_ beats.
// Depends on osr_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_oversampled_serial_receiver_unit;

    localparam int unsigned QUIET_LIMIT   = 3000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned ITEM_TARGET   = 1350;

    typedef enum logic [1:0] {
        RX_HUNT = 2'd0,
        RX_SKIP = 2'd1,
        RX_BITS = 2'd2
    } rx_phase_t;

    class rx_scoreboard;
        logic [osr_pkg::PERIOD_W-1:0] period;
        rx_phase_t                    phase;
        logic [3:0]                   low_run;
        logic [3:0]                   nbits;
        logic [osr_pkg::PERIOD_W-1:0] count;
        logic [osr_pkg::PERIOD_W-1:0] high_votes;
        logic [osr_pkg::PERIOD_W-1:0] low_votes;
        logic [osr_pkg::BYTE_W-1:0]   shreg;
        logic                         par;
        osr_pkg::osr_result_t         expected_bytes[$];
        int unsigned                  errors;
        int unsigned                  samples;
        int unsigned                  bytes_seen;

        function new();
            period     = osr_pkg::BIT_PERIOD_RESET;
            errors     = 0;
            samples    = 0;
            bytes_seen = 0;
            restart();
        endfunction

        function void clear_window();
            count      = '0;
            high_votes = '0;
            low_votes  = '0;
        endfunction

        function void restart();
            phase   = RX_HUNT;
            low_run = '0;
            nbits   = '0;
            shreg   = '0;
            par     = 1'b0;
            clear_window();
        endfunction

        function void set_period(logic [osr_pkg::PERIOD_W-1:0] p);
            period = p;
        endfunction

        function bit hunting();
            return phase == RX_HUNT;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void note_sample(logic level);
            logic                 vote;
            osr_pkg::osr_result_t r;
            samples++;
            case (phase)
                RX_SKIP: begin
                    count = count + 1'b1;
                    if (count >= period) begin
                        phase = RX_BITS;
                        clear_window();
                    end
                end
                RX_BITS: begin
                    if (level) high_votes = high_votes + 1'b1;
                    else low_votes = low_votes + 1'b1;
                    count = count + 1'b1;
                    if (count >= period) begin
                        // tie votes resolve to 0
                        vote = (high_votes > low_votes);
                        clear_window();
                        if (nbits < osr_pkg::DATA_BITS) begin
                            shreg = {shreg[osr_pkg::BYTE_W-2:0], vote};
                            par   = par ^ vote;
                            nbits = nbits + 1'b1;
                        end else begin
                            r.received_byte = shreg;
                            r.parity_error  = par ^ vote;
                            expected_bytes.push_back(r);
                            restart();
                        end
                    end
                end
                default: begin
                    phase = RX_HUNT;
                    if (level) begin
                        low_run = '0;
                    end else if (low_run >= osr_pkg::START_RUN_LIMIT) begin
                        restart();
                        // start bit counted from the first low of the run
                        count = osr_pkg::PERIOD_W'(osr_pkg::START_RUN_LIMIT + 1);
                        if (count < period) begin
                            phase = RX_SKIP;
                        end else begin
                            phase = RX_BITS;
                            clear_window();
                        end
                    end else begin
                        low_run = low_run + 1'b1;
                    end
                end
            endcase
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(input logic [osr_pkg::BYTE_W-1:0] rx_byte, input logic rx_perr);
            osr_pkg::osr_result_t want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected beat byte=%02h parity_error=%0b",
                                 rx_byte, rx_perr));
                return;
            end
            want = expected_bytes.pop_front();
            bytes_seen++;
            if (rx_byte !== want.received_byte)
                report($sformatf("received_byte %02h, want %02h", rx_byte, want.received_byte));
            if (rx_perr !== want.parity_error)
                report($sformatf("parity_error %0b, want %0b (byte %02h)",
                                 rx_perr, want.parity_error, want.received_byte));
        endtask
    endclass

    logic                         aclk;
    logic                         aresetn       = 1'b0;
    logic                         s_valid       = 1'b0;
    logic                         s_ready;
    logic                         s_line_sample = 1'b1;
    logic                         m_valid;
    logic                         m_ready       = 1'b0;
    logic [osr_pkg::BYTE_W-1:0]   m_received_byte;
    logic                         m_parity_error;
    logic                         cfg_valid     = 1'b0;
    logic                         cfg_ready;
    logic [osr_pkg::PERIOD_W-1:0] cfg_data      = '0;

    rx_scoreboard sb = new();

    bit          steady       = 1'b1;
    int unsigned burst_left   = 0;
    int unsigned hold_asks    = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_age    = 0;
    int unsigned stall_phase  = 0;
    logic [15:0] stall_mask   = '0;
    int unsigned quiet        = 0;
    int unsigned settings_used = 0;

    oversampled_serial_receiver_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_line_sample   (s_line_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_received_byte (m_received_byte),
        .m_parity_error  (m_parity_error),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: random stall pattern, redrawn when stall_age runs out, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (stall_age == 0) begin
            stall_age = 64;
            case ($urandom_range(0, 3))
                0: stall_mask = '0;
                1: stall_mask = 16'($urandom);
                2: stall_mask = 16'($urandom & $urandom);
                default: stall_mask = 16'($urandom | $urandom);
            endcase
        end
        stall_age--;
        stall_phase++;
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !stall_mask[stall_phase % 16];
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_received_byte, m_parity_error);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", quiet);
            $display("oversampled_serial_receiver_unit regression: fail");
            $finish;
        end
    end

    task automatic send_sample(input logic level);
        int unsigned gap;
        if (!steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        if (burst_left != 0) burst_left--;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_line_sample <= level;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(level);
    endtask

    task automatic write_period(input logic [osr_pkg::PERIOD_W-1:0] p);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_period(p);
        settings_used++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // noise: flip each sample with probability noise/16 (start run stays clean)
    task automatic send_frame(input logic [osr_pkg::BYTE_W-1:0] data, input bit bad_parity,
                              input int unsigned noise);
        int unsigned win;
        int unsigned lead;
        logic [8:0]  frame_bits;
        repeat ($urandom_range(1, 4)) send_sample(1'b1);
        win  = (sb.period == 0) ? 1 : sb.period;
        lead = (sb.period > osr_pkg::START_RUN_LIMIT + 1) ? sb.period
                                                          : osr_pkg::START_RUN_LIMIT + 1;
        for (int unsigned i = 0; i < lead; i++) begin
            if (i <= osr_pkg::START_RUN_LIMIT) send_sample(1'b0);
            else send_sample(1'b0 ^ ($urandom_range(0, 15) < noise));
        end
        frame_bits = {data, ^data ^ bad_parity};
        for (int b = 8; b >= 0; b--) begin
            for (int unsigned i = 0; i < win; i++)
                send_sample(frame_bits[b] ^ ($urandom_range(0, 15) < noise));
        end
        repeat ($urandom_range(1, 4)) send_sample(1'b1);
    endtask

    // short low runs, false starts and random line chatter
    task automatic send_noise();
        int unsigned run;
        repeat ($urandom_range(2, 8)) begin
            if ($urandom_range(0, 1)) begin
                run = $urandom_range(1, 14);
                repeat (run) send_sample(1'b0);
                send_sample(1'b1);
            end else begin
                send_sample(1'($urandom_range(0, 1)));
            end
        end
    endtask

    // drive idle line until any frame in flight completes, then drain results
    task automatic finish_phase();
        while (!sb.hunting()) send_sample(1'b1);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int unsigned                  near_start[3];
        logic [osr_pkg::PERIOD_W-1:0] p;
        near_start = '{10, 11, 12};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        steady = 1'b0;
        write_period(10'd3);
        send_frame(8'h00, 1'b0, 0);
        send_frame(8'hFF, 1'b0, 0);
        send_frame(8'h80, 1'b0, 0);
        send_frame(8'h01, 1'b1, 0);
        repeat (osr_pkg::START_RUN_LIMIT) send_sample(1'b0);   // one low short of a start
        send_sample(1'b1);
        send_frame(8'h5A, 1'b0, 0);
        finish_phase();

        // even window with heavy noise: tie votes
        write_period(10'd2);
        send_frame(8'hC3, 1'b0, 8);
        send_frame(8'h3C, 1'b1, 8);
        finish_phase();

        write_period('0);
        send_frame(8'h96, 1'b0, 0);
        send_frame(8'h69, 1'b1, 2);
        finish_phase();

        // hold off the output while frames keep coming, so the input stalls
        write_period(10'd1);
        hold_asks++;
        repeat (8) send_frame(8'($urandom), 1'($urandom_range(0, 1)), 0);
        finish_phase();

        foreach (near_start[i]) begin
            write_period(osr_pkg::PERIOD_W'(near_start[i]));
            send_frame(8'($urandom), 1'($urandom_range(0, 1)), 1);
            finish_phase();
        end

        while (sb.samples < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: p = '0;
                1: p = osr_pkg::PERIOD_W'($urandom_range(9, 16));
                2: p = osr_pkg::PERIOD_W'($urandom_range(17, 40));
                default: p = osr_pkg::PERIOD_W'($urandom_range(1, 8));
            endcase
            write_period(p);
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) hold_asks++;
            repeat ($urandom_range(2, 6)) begin
                if (sb.samples >= ITEM_TARGET) break;
                if ($urandom_range(0, 6) == 0)
                    send_noise();
                else
                    send_frame(8'($urandom), ($urandom_range(0, 3) == 0),
                               ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2)
                                                          : $urandom_range(6, 8));
            end
            finish_phase();
        end

        $display("covered %0d line samples and %0d received bytes over %0d bit-period writes",
                 sb.samples, sb.bytes_seen, settings_used);
        $display("periods included 0, 1, the start-run boundary and random values up to 40");
        if (sb.errors == 0) begin
            $display("oversampled_serial_receiver_unit regression: pass");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("oversampled_serial_receiver_unit regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
design/osr_pkg.sv
design/osr_core.sv
design/osr_out_buf.sv
design/oversampled_serial_receiver_unit.sv
test/tb_oversampled_serial_receiver_unit.sv
